// ----- hdl/artl_pkg.sv -----
// ----------------------------------------------------------------------------
// artl_pkg
// Shared types, codes and constants of the ageing route table.
// ----------------------------------------------------------------------------
package artl_pkg;

    // Default sizes of the table and of the port set.
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_PORTS_DEF     = 8;

    // Most hops that one flood may emit.
    localparam int FLOOD_MAX = 8;

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int MAC_W  = 48;
    localparam int PORT_W = 3;
    localparam int DIST_W = 8;
    localparam int AGE_W  = 2;
    localparam int OP_W   = 2;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 4;
    localparam int LCNT_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Operation codes of an input item. The spare code is taken and dropped.
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_UPD_DONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ROUTE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLOOD    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC_B  = 3'd5;

    localparam logic [ADDR_W-1:0] ADDR_BCAST = 32'hffff_ffff;
    localparam logic [MAC_W-1:0]  MAC_BCAST  = 48'hffff_ffff_ffff;

    // Query and running scan results that move from cell to cell.
    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] qmask;
        logic [AGE_W-1:0]  stale;
        logic              hit;
        logic [AGE_W-1:0]  hit_age;
        logic [DIST_W-1:0] hit_dist;
        logic              free_ok;
        logic              best_ok;
        logic [ADDR_W-1:0] best_mask;
        logic [ADDR_W-1:0] best_prefix;
        logic [MAC_W-1:0]  best_mac;
        logic [PORT_W-1:0] best_port;
    } t_carry;

    // Entry write broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [DIST_W-1:0] distance;
        logic [AGE_W-1:0]  age;
    } t_wr;

endpackage

// ----- hdl/artl_in_if.sv -----
// ----------------------------------------------------------------------------
// artl_in_if
// Input channel of the route table: one request item per handshake.
// ----------------------------------------------------------------------------
interface artl_in_if;
    logic                      valid;
    logic                      ready;
    logic [artl_pkg::OP_W-1:0]   op;
    logic [artl_pkg::ADDR_W-1:0] dest_addr;
    logic [artl_pkg::ADDR_W-1:0] prefix_mask;
    logic [artl_pkg::MAC_W-1:0]  next_hop_mac;
    logic [artl_pkg::PORT_W-1:0] port_id;
    logic [artl_pkg::DIST_W-1:0] hop_distance;

    modport source (output valid, op, dest_addr, prefix_mask, next_hop_mac, port_id,
                    hop_distance, input ready);
    modport sink (input valid, op, dest_addr, prefix_mask, next_hop_mac, port_id,
                  hop_distance, output ready);
endinterface

// ----- hdl/artl_out_if.sv -----
// ----------------------------------------------------------------------------
// artl_out_if
// Output channel of the route table: one result item per handshake.
// ----------------------------------------------------------------------------
interface artl_out_if;
    logic                        valid;
    logic                        ready;
    logic [artl_pkg::KIND_W-1:0] kind;
    logic [artl_pkg::MAC_W-1:0]  hop_mac;
    logic [artl_pkg::PORT_W-1:0] hop_port;
    logic                        last;

    modport source (output valid, kind, hop_mac, hop_port, last, input ready);
    modport sink (input valid, kind, hop_mac, hop_port, last, output ready);
endinterface

// ----- hdl/aging_route_table_lpm.sv -----
// ----------------------------------------------------------------------------
// aging_route_table_lpm
// Ageing longest-prefix-match route table built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Each item (update, lookup or tick) is launched into a chain of
// TABLE_ENTRIES cells, one per table entry, and moves one cell per cycle;
// the sequencer then turns the scan result into an entry write where one
// is due and into result items, one per output handshake (up to eight
// hops for a flood). One item is handled at a time; an item with the spare
// operation code is taken and dropped.
// Entry valid flags are cleared by reset, so no clearing pass is needed.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, which the block itself does not enforce;
// register indexes follow the order device_count, local_count,
// local_ip_a, local_mac_a, local_ip_b, local_mac_b.
module aging_route_table_lpm #(
    parameter int TABLE_ENTRIES = artl_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PORTS     = artl_pkg::MAX_PORTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    artl_in_if.sink                         i_item,
    artl_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [artl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [artl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import artl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    t_carry        w_carry    [TABLE_ENTRIES+1];
    logic [IW-1:0] w_hit_idx  [TABLE_ENTRIES+1];
    logic [IW-1:0] w_free_idx [TABLE_ENTRIES+1];
    t_wr           w_wr;
    logic [IW-1:0] w_wr_idx;
    logic [IW-1:0] w_head_idx;

    assign w_hit_idx[0]  = w_head_idx;
    assign w_free_idx[0] = w_head_idx;

    // Sequencer and configuration.
    artl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_PORTS     (MAX_PORTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .o_res           (o_res),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_head          (w_carry[0]),
        .o_head_idx      (w_head_idx),
        .i_tail          (w_carry[TABLE_ENTRIES]),
        .i_tail_hit_idx  (w_hit_idx[TABLE_ENTRIES]),
        .i_tail_free_idx (w_free_idx[TABLE_ENTRIES]),
        .o_wr            (w_wr),
        .o_wr_idx        (w_wr_idx)
    );

    // Row of entry cells.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        artl_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IW'(g)),
            .i_carry    (w_carry[g]),
            .i_hit_idx  (w_hit_idx[g]),
            .i_free_idx (w_free_idx[g]),
            .o_carry    (w_carry[g+1]),
            .o_hit_idx  (w_hit_idx[g+1]),
            .o_free_idx (w_free_idx[g+1]),
            .i_wr       (w_wr),
            .i_wr_idx   (w_wr_idx)
        );
    end

endmodule

// ----- hdl/artl_cell.sv -----
// ----------------------------------------------------------------------------
// artl_cell
// One table entry. Examines the passing query against its entry and hands
// the updated running result on to the next cell through its hand-over register.
// ----------------------------------------------------------------------------
module artl_cell #(
    parameter int TABLE_ENTRIES = artl_pkg::TABLE_ENTRIES_DEF,
    localparam int IW = $clog2(TABLE_ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IW-1:0]    i_idx,
    input  artl_pkg::t_carry i_carry,
    input  logic [IW-1:0]    i_hit_idx,
    input  logic [IW-1:0]    i_free_idx,
    output artl_pkg::t_carry o_carry,
    output logic [IW-1:0]    o_hit_idx,
    output logic [IW-1:0]    o_free_idx,
    input  artl_pkg::t_wr    i_wr,
    input  logic [IW-1:0]    i_wr_idx
);
    import artl_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_prefix;
    logic [ADDR_W-1:0] r_mask;
    logic [MAC_W-1:0]  r_mac;
    logic [PORT_W-1:0] r_port;
    logic [DIST_W-1:0] r_dist;
    logic [AGE_W-1:0]  r_age;

    t_carry          r_carry, n_carry;
    logic [IW-1:0]   r_hit_idx, n_hit_idx;
    logic [IW-1:0]   r_free_idx, n_free_idx;
    logic            w_wr_here;
    logic            w_expire;
    logic            w_cover;

    assign w_wr_here = i_wr.en && (i_wr_idx == i_idx);
    assign w_expire  = i_carry.vld && (i_carry.op == OP_TICK) && r_valid
                       && (r_age == i_carry.stale);
    assign w_cover   = ((r_prefix & r_mask) == (i_carry.addr & r_mask))
                       && ((r_mask & i_carry.qmask) == r_mask);

    // Fold this entry into the running result.
    always_comb begin
        n_carry    = i_carry;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        if (i_carry.vld && i_carry.op == OP_UPDATE) begin
            if (r_valid) begin
                if (!i_carry.hit && r_prefix == i_carry.addr && r_mask == i_carry.qmask) begin
                    n_carry.hit      = 1'b1;
                    n_carry.hit_age  = r_age;
                    n_carry.hit_dist = r_dist;
                    n_hit_idx        = i_idx;
                end
            end else if (!i_carry.free_ok) begin
                n_carry.free_ok = 1'b1;
                n_free_idx      = i_idx;
            end
        end
        if (i_carry.vld && i_carry.op == OP_LOOKUP && r_valid && w_cover) begin
            if (!i_carry.best_ok || r_mask > i_carry.best_mask
                || (r_mask == i_carry.best_mask && r_prefix < i_carry.best_prefix)) begin
                n_carry.best_ok     = 1'b1;
                n_carry.best_mask   = r_mask;
                n_carry.best_prefix = r_prefix;
                n_carry.best_mac    = r_mac;
                n_carry.best_port   = r_port;
            end
        end
    end

    // Entry valid flag: set by a write, cleared when it expires on a tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_wr_here) begin
            r_valid <= 1'b1;
        end else if (w_expire) begin
            r_valid <= 1'b0;
        end
    end

    // Entry contents.
    always_ff @(posedge i_clk) begin
        if (w_wr_here) begin
            r_prefix <= i_wr.prefix;
            r_mask   <= i_wr.mask;
            r_mac    <= i_wr.mac;
            r_port   <= i_wr.port;
            r_dist   <= i_wr.distance;
            r_age    <= i_wr.age;
        end
    end

    // Hand-over register to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.vld <= 1'b0;
        end else begin
            r_carry.vld <= n_carry.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry.op          <= n_carry.op;
        r_carry.addr        <= n_carry.addr;
        r_carry.qmask       <= n_carry.qmask;
        r_carry.stale       <= n_carry.stale;
        r_carry.hit         <= n_carry.hit;
        r_carry.hit_age     <= n_carry.hit_age;
        r_carry.hit_dist    <= n_carry.hit_dist;
        r_carry.free_ok     <= n_carry.free_ok;
        r_carry.best_ok     <= n_carry.best_ok;
        r_carry.best_mask   <= n_carry.best_mask;
        r_carry.best_prefix <= n_carry.best_prefix;
        r_carry.best_mac    <= n_carry.best_mac;
        r_carry.best_port   <= n_carry.best_port;
        r_hit_idx           <= n_hit_idx;
        r_free_idx          <= n_free_idx;
    end

    assign o_carry    = r_carry;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

// ----- hdl/artl_ctrl.sv -----
// ----------------------------------------------------------------------------
// artl_ctrl
// Sequencer of the route table: takes an item, launches it into the cell
// chain, turns the scan result into writes and result items, and holds the
// configuration registers and the age clock.
// ----------------------------------------------------------------------------
module artl_ctrl #(
    parameter int TABLE_ENTRIES = artl_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PORTS     = artl_pkg::MAX_PORTS_DEF,
    localparam int IW = $clog2(TABLE_ENTRIES)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    artl_in_if.sink                            i_item,
    artl_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [artl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [artl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output artl_pkg::t_carry                   o_head,
    output logic [IW-1:0]                      o_head_idx,
    input  artl_pkg::t_carry                   i_tail,
    input  logic [IW-1:0]                      i_tail_hit_idx,
    input  logic [IW-1:0]                      i_tail_free_idx,
    output artl_pkg::t_wr                      o_wr,
    output logic [IW-1:0]                      o_wr_idx
);
    import artl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam int PORT_CAP = (MAX_PORTS < FLOOD_MAX) ? MAX_PORTS : FLOOD_MAX;
    localparam logic [CNT_W-1:0] PORT_CAP_C = CNT_W'(PORT_CAP);

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_dev_cnt;
    logic [LCNT_W-1:0] r_loc_cnt;
    logic [ADDR_W-1:0] r_ip_a, r_ip_b;
    logic [MAC_W-1:0]  r_mac_a, r_mac_b;
    logic [AGE_W-1:0]  r_age_clk;

    t_carry            r_head;
    logic [MAC_W-1:0]  r_upd_mac;
    logic [PORT_W-1:0] r_upd_port;
    logic [DIST_W-1:0] r_upd_dist;

    t_wr               r_wr;
    logic [IW-1:0]     r_wr_idx;

    logic [KIND_W-1:0] r_kind;
    logic [MAC_W-1:0]  r_mac;
    logic [PORT_W-1:0] r_port;
    logic              r_last;
    logic              r_flood;
    logic [CNT_W-1:0]  r_fl_n;
    logic [CNT_W-1:0]  r_fl_cnt;

    logic              w_acc;
    logic              w_out_acc;
    logic [MAC_W-1:0]  w_sub_mac;
    logic [DIST_W-1:0] w_sub_dist;
    logic [CNT_W-1:0]  w_fl_n;
    logic              w_do_flood;
    logic              w_replace;
    logic [CNT_W-1:0]  w_next_cnt;

    assign w_acc     = i_item.valid && i_item.ready;
    assign w_out_acc = o_res.valid && o_res.ready;

    assign i_item.ready = (r_state == ST_IDLE);
    assign o_res.valid  = (r_state == ST_OUT);
    assign o_res.kind     = r_kind;
    assign o_res.hop_mac  = r_mac;
    assign o_res.hop_port = r_port;
    assign o_res.last     = r_last;

    assign o_head     = r_head;
    assign o_head_idx = '0;
    assign o_wr       = r_wr;
    assign o_wr_idx   = r_wr_idx;

    // Same-host destination takes the local port's MAC at distance zero.
    always_comb begin
        w_sub_mac  = i_item.next_hop_mac;
        w_sub_dist = i_item.hop_distance;
        if (r_loc_cnt != 2'd0 && i_item.dest_addr == r_ip_a) begin
            w_sub_mac  = r_mac_a;
            w_sub_dist = '0;
        end
        if (r_loc_cnt[1] && i_item.dest_addr == r_ip_b) begin
            w_sub_mac  = r_mac_b;
            w_sub_dist = '0;
        end
    end

    // Number of hops in a flood, clamped to the port range.
    always_comb begin
        if (r_dev_cnt == '0) begin
            w_fl_n = CNT_W'(1);
        end else if (r_dev_cnt > PORT_CAP_C) begin
            w_fl_n = PORT_CAP_C;
        end else begin
            w_fl_n = r_dev_cnt;
        end
    end

    assign w_do_flood = (i_tail.addr == ADDR_BCAST) || !i_tail.best_ok;
    assign w_replace  = (i_tail.hit_age == i_tail.stale) || (i_tail.hit_dist >= r_upd_dist);
    assign w_next_cnt = r_fl_cnt + CNT_W'(1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_cnt <= CNT_W'(1);
            r_loc_cnt <= '0;
            r_ip_a    <= '0;
            r_ip_b    <= '0;
            r_mac_a   <= '0;
            r_mac_b   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEVICE_COUNT: r_dev_cnt <= i_cfg_data[CNT_W-1:0];
                REG_LOCAL_COUNT:  r_loc_cnt <= i_cfg_data[LCNT_W-1:0];
                REG_LOCAL_IP_A:   r_ip_a    <= i_cfg_data[ADDR_W-1:0];
                REG_LOCAL_MAC_A:  r_mac_a   <= i_cfg_data[MAC_W-1:0];
                REG_LOCAL_IP_B:   r_ip_b    <= i_cfg_data[ADDR_W-1:0];
                REG_LOCAL_MAC_B:  r_mac_b   <= i_cfg_data[MAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state, age clock and write strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_age_clk  <= '0;
            r_head.vld <= 1'b0;
            r_wr.en    <= 1'b0;
        end else begin
            r_head.vld <= 1'b0;
            r_wr.en    <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_item.op != OP_NONE) begin
                        r_head.vld <= 1'b1;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (i_tail.vld) begin
                        r_state <= ST_OUT;
                        if (i_tail.op == OP_TICK) begin
                            r_age_clk <= i_tail.stale;
                        end
                        if (i_tail.op == OP_UPDATE
                            && ((i_tail.hit && w_replace) || (!i_tail.hit && i_tail.free_ok))) begin
                            r_wr.en <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_acc && (!r_flood || w_next_cnt == r_fl_n)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Item payload launched into the chain.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_head.op          <= i_item.op;
            r_head.addr        <= i_item.dest_addr;
            r_head.qmask       <= i_item.prefix_mask;
            r_head.stale       <= r_age_clk + AGE_W'(1);
            r_head.hit         <= 1'b0;
            r_head.hit_age     <= '0;
            r_head.hit_dist    <= '0;
            r_head.free_ok     <= 1'b0;
            r_head.best_ok     <= 1'b0;
            r_head.best_mask   <= '0;
            r_head.best_prefix <= '0;
            r_head.best_mac    <= '0;
            r_head.best_port   <= '0;
            r_upd_mac          <= w_sub_mac;
            r_upd_port         <= i_item.port_id;
            r_upd_dist         <= w_sub_dist;
        end
    end

    // Entry write contents and target slot.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && i_tail.vld) begin
            r_wr.prefix   <= i_tail.addr;
            r_wr.mask     <= i_tail.qmask;
            r_wr.mac      <= r_upd_mac;
            r_wr.port     <= r_upd_port;
            r_wr.distance <= r_upd_dist;
            r_wr.age      <= r_age_clk;
            r_wr_idx      <= i_tail.hit ? i_tail_hit_idx : i_tail_free_idx;
        end
    end

    // Result item register, stepped through the ports while flooding.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && i_tail.vld) begin
            r_mac    <= '0;
            r_port   <= '0;
            r_last   <= 1'b1;
            r_flood  <= 1'b0;
            r_fl_cnt <= '0;
            r_fl_n   <= w_fl_n;
            case (i_tail.op)
                OP_UPDATE: begin
                    r_kind <= (!i_tail.hit && !i_tail.free_ok) ? KIND_FULL : KIND_UPD_DONE;
                end
                OP_LOOKUP: begin
                    if (w_do_flood) begin
                        r_kind  <= KIND_FLOOD;
                        r_mac   <= MAC_BCAST;
                        r_flood <= 1'b1;
                        r_last  <= (w_fl_n == CNT_W'(1));
                    end else begin
                        r_kind <= KIND_ROUTE;
                        r_mac  <= i_tail.best_mac;
                        r_port <= i_tail.best_port;
                    end
                end
                default: r_kind <= KIND_TICK;
            endcase
        end else if (r_state == ST_OUT && w_out_acc && r_flood) begin
            r_fl_cnt <= w_next_cnt;
            r_port   <= w_next_cnt[PORT_W-1:0];
            r_last   <= (w_next_cnt + CNT_W'(1) == r_fl_n);
        end
    end

endmodule

// ----- sim/tb_aging_route_table_lpm.sv -----
// ----------------------------------------------------------------------------
// tb_aging_route_table_lpm
// Self-checking testbench of the ageing longest-prefix-match route table.
// A route predictor in the scoreboard class mirrors the table, the age clock
// and the configuration, and each result item is compared field by field
// with the oldest expected hop. Directed items come first, then random items
// across idle and stall phases, with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_aging_route_table_lpm;
    timeunit 1ns;
    timeprecision 1ps;
    import artl_pkg::*;

    localparam int ENTRIES = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic              last;
    } t_hop;

    // Route predictor and store of expected hops.
    class route_scoreboard;
        bit                entry_valid[ENTRIES];
        logic [ADDR_W-1:0] entry_prefix[ENTRIES];
        logic [ADDR_W-1:0] entry_mask[ENTRIES];
        logic [MAC_W-1:0]  entry_mac[ENTRIES];
        logic [PORT_W-1:0] entry_port[ENTRIES];
        logic [DIST_W-1:0] entry_dist[ENTRIES];
        logic [AGE_W-1:0]  entry_age[ENTRIES];
        logic [AGE_W-1:0]  age_clock;
        logic [CNT_W-1:0]  device_count;
        logic [LCNT_W-1:0] local_count;
        logic [ADDR_W-1:0] ip_a, ip_b;
        logic [MAC_W-1:0]  mac_a, mac_b;
        t_hop              expected_hops[$];
        int                errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) entry_valid[i] = 0;
            age_clock = '0;
            device_count = CNT_W'(1);
            local_count = '0;
            ip_a = '0; ip_b = '0; mac_a = '0; mac_b = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEVICE_COUNT: device_count = val[CNT_W-1:0];
                REG_LOCAL_COUNT:  local_count = val[LCNT_W-1:0];
                REG_LOCAL_IP_A:   ip_a = val[ADDR_W-1:0];
                REG_LOCAL_MAC_A:  mac_a = val[MAC_W-1:0];
                REG_LOCAL_IP_B:   ip_b = val[ADDR_W-1:0];
                REG_LOCAL_MAC_B:  mac_b = val[MAC_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_hop(logic [KIND_W-1:0] k, logic [MAC_W-1:0] m,
                               logic [PORT_W-1:0] p, logic l);
            t_hop h;
            h.kind = k; h.mac = m; h.port = p; h.last = l;
            expected_hops.insert(expected_hops.size(), h);
        endfunction

        function void push_flood();
            int n;
            n = int'(device_count);
            if (n == 0) n = 1;
            if (n > 8) n = 8;
            for (int i = 0; i < n; i++)
                push_hop(KIND_FLOOD, MAC_BCAST, PORT_W'(i), i == n - 1);
        endfunction

        // Note one accepted request and predict its hops.
        function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] qmask, logic [MAC_W-1:0] mac,
                                   logic [PORT_W-1:0] port, logic [DIST_W-1:0] hop_dist);
            logic [AGE_W-1:0] stale;
            int hit, free_slot, best;
            stale = age_clock + 2'd1;
            hit = -1; free_slot = -1; best = -1;
            case (op)
                OP_UPDATE: begin
                    if (local_count >= 1 && addr == ip_a) begin
                        mac = mac_a; hop_dist = '0;
                    end
                    if (local_count >= 2 && addr == ip_b) begin
                        mac = mac_b; hop_dist = '0;
                    end
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (entry_valid[i]) begin
                            if (hit < 0 && entry_prefix[i] == addr && entry_mask[i] == qmask)
                                hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit < 0 && free_slot < 0) begin
                        push_hop(KIND_FULL, '0, '0, 1'b1);
                        return;
                    end
                    push_hop(KIND_UPD_DONE, '0, '0, 1'b1);
                    if (hit >= 0 && !(entry_age[hit] == stale || entry_dist[hit] >= hop_dist))
                        return;
                    if (hit < 0) hit = free_slot;
                    entry_valid[hit] = 1;
                    entry_prefix[hit] = addr;
                    entry_mask[hit] = qmask;
                    entry_mac[hit] = mac;
                    entry_port[hit] = port;
                    entry_dist[hit] = hop_dist;
                    entry_age[hit] = age_clock;
                end
                OP_LOOKUP: begin
                    if (addr == ADDR_BCAST) begin
                        push_flood();
                        return;
                    end
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!entry_valid[i]) continue;
                        if ((entry_prefix[i] & entry_mask[i]) != (addr & entry_mask[i])) continue;
                        if ((entry_mask[i] & qmask) != entry_mask[i]) continue;
                        if (best < 0 || entry_mask[i] > entry_mask[best] ||
                            (entry_mask[i] == entry_mask[best] &&
                             entry_prefix[i] < entry_prefix[best]))
                            best = i;
                    end
                    if (best < 0) push_flood();
                    else push_hop(KIND_ROUTE, entry_mac[best], entry_port[best], 1'b1);
                end
                OP_TICK: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (entry_valid[i] && entry_age[i] == stale) entry_valid[i] = 0;
                    age_clock = stale;
                    push_hop(KIND_TICK, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            errors++;
        endfunction

        // Compare one accepted result item with the oldest expectation.
        function void check_hop(t_hop got);
            t_hop want;
            if (expected_hops.size() == 0) begin
                report($sformatf("unexpected result kind=%0d", got.kind));
                return;
            end
            want = expected_hops.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.mac !== want.mac)
                report($sformatf("hop_mac got %h want %h", got.mac, want.mac));
            if (got.port !== want.port)
                report($sformatf("hop_port got %0d want %0d", got.port, want.port));
            if (got.last !== want.last)
                report($sformatf("last got %0d want %0d", got.last, want.last));
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    artl_in_if  req_ch();
    artl_out_if res_ch();

    aging_route_table_lpm dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(req_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    route_scoreboard sb = new();

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  quiet_cycles = 0;
    logic [ADDR_W-1:0] prefix_pool[8];

    // Clock.
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    initial begin
        req_ch.valid = 0;
        req_ch.op = '0;
        req_ch.dest_addr = '0;
        req_ch.prefix_mask = '0;
        req_ch.next_hop_mac = '0;
        req_ch.port_id = '0;
        req_ch.hop_distance = '0;
        res_ch.ready = 0;
    end

    // Receiver: random stall, decided at the falling edge.
    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (res_ch.valid && res_ch.ready)
                sb.check_hop({res_ch.kind, res_ch.hop_mac, res_ch.hop_port, res_ch.last});
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one request and wait for its acceptance. Valid stays up after
    // the acceptance until the next request or drain() takes it down.
    task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                logic [ADDR_W-1:0] qmask, logic [MAC_W-1:0] mac,
                                logic [PORT_W-1:0] port, logic [DIST_W-1:0] hop_dist);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.op <= op;
        req_ch.dest_addr <= addr;
        req_ch.prefix_mask <= qmask;
        req_ch.next_hop_mac <= mac;
        req_ch.port_id <= port;
        req_ch.hop_distance <= hop_dist;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, addr, qmask, mac, port, hop_dist);
        @(negedge i_clk);
    endtask

    // Wait until every expected hop has arrived, plus the scan latency.
    task automatic drain();
        req_ch.valid <= 0;
        while (sb.expected_hops.size() != 0) @(negedge i_clk);
        repeat (ENTRIES + 20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    task automatic setup(logic [3:0] devs, logic [1:0] lcnt);
        write_reg(REG_DEVICE_COUNT, CFG_DATA_W'(devs));
        write_reg(REG_LOCAL_COUNT, CFG_DATA_W'(lcnt));
        write_reg(REG_LOCAL_IP_A, CFG_DATA_W'(prefix_pool[$urandom_range(7)]));
        write_reg(REG_LOCAL_MAC_A, rand_mac());
        write_reg(REG_LOCAL_IP_B, $urandom_range(1) ? CFG_DATA_W'(prefix_pool[$urandom_range(7)])
                                                    : CFG_DATA_W'(sb.ip_a));
        write_reg(REG_LOCAL_MAC_B, rand_mac());
    endtask

    function automatic logic [ADDR_W-1:0] rand_mask();
        int len;
        len = $urandom_range(32);
        return (len == 0) ? 32'd0 : ~(32'hffff_ffff >> len);
    endfunction

    // One random request: mostly updates and lookups on a small prefix pool.
    task automatic random_request();
        int sel;
        logic [ADDR_W-1:0] addr, mask;
        logic [DIST_W-1:0] hd;
        sel = $urandom_range(99);
        addr = ($urandom_range(3) == 0) ? ADDR_W'($urandom) : prefix_pool[$urandom_range(7)];
        mask = ($urandom_range(4) == 0) ? ADDR_W'($urandom) : rand_mask();
        hd = ($urandom_range(3) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(4));
        if (sel < 45)
            send_request(OP_UPDATE, addr, mask, rand_mac(), PORT_W'($urandom), hd);
        else if (sel < 85)
            send_request(OP_LOOKUP, $urandom_range(15) == 0 ? ADDR_BCAST : addr,
                         $urandom_range(1) ? 32'hffff_ffff : mask, rand_mac(),
                         PORT_W'($urandom), DIST_W'($urandom));
        else if (sel < 95)
            send_request(OP_TICK, ADDR_W'($urandom), ADDR_W'($urandom), rand_mac(),
                         PORT_W'($urandom), DIST_W'($urandom));
        else
            send_request(OP_NONE, ADDR_W'($urandom), ADDR_W'($urandom), rand_mac(),
                         PORT_W'($urandom), DIST_W'($urandom));
    endtask

    initial begin
        for (int i = 0; i < 8; i++) prefix_pool[i] = $urandom;
        prefix_pool[0] = 32'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed part: extremes, every operation, local hosts, staleness.
        setup(4'd8, 2'd2);
        write_reg(REG_LOCAL_IP_A, CFG_DATA_W'(32'h0a00_0001));
        write_reg(REG_LOCAL_IP_B, CFG_DATA_W'(32'h0a00_0001));
        send_request(OP_LOOKUP, 32'h0a00_0001, 32'hffff_ffff, '0, '0, '0);
        send_request(OP_UPDATE, 32'h0a00_0000, 32'hff00_0000, 48'h1111, 3'd1, 8'd5);
        send_request(OP_UPDATE, 32'h0a00_0000, 32'hffff_0000, 48'h2222, 3'd2, 8'd5);
        send_request(OP_UPDATE, 32'h0a00_0001, 32'hffff_ffff, 48'h3333, 3'd7, 8'hff);
        send_request(OP_UPDATE, 32'h0a00_0000, 32'hff00_0000, 48'h4444, 3'd3, 8'd9);
        send_request(OP_UPDATE, 32'h0a00_0000, 32'hff00_0000, 48'hffff_ffff_ffff, 3'd4, 8'd0);
        send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 48'h5555, 3'd0, 8'd0);
        send_request(OP_LOOKUP, 32'h0a00_0001, 32'hffff_ffff, '0, '0, '0);
        send_request(OP_LOOKUP, 32'h0a00_0001, 32'hff00_0000, '0, '0, '0);
        send_request(OP_LOOKUP, 32'h0b00_0001, 32'hffff_ffff, '0, '0, '0);
        send_request(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0, '0, '0);
        send_request(OP_TICK, 32'hffff_ffff, 32'hffff_ffff, '1, '1, '1);
        send_request(OP_UPDATE, 32'h0a00_0000, 32'hff00_0000, 48'h6666, 3'd5, 8'd200);
        send_request(OP_TICK, '0, '0, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0, '0, '0);
        send_request(OP_LOOKUP, 32'h0a00_0001, 32'hffff_ffff, '0, '0, '0);
        send_request(OP_NONE, '1, '1, '1, '1, '1);
        drain();

        // Fill the table and overflow it.
        setup(4'd0, 2'd3);
        for (int i = 0; i < ENTRIES + 2; i++)
            send_request(OP_UPDATE, ADDR_W'(32'hc0a8_0000 + i), 32'hffff_ffff, rand_mac(),
                         PORT_W'($urandom), DIST_W'($urandom));
        send_request(OP_LOOKUP, 32'hc0a8_0005, 32'hffff_ffff, '0, '0, '0);
        drain();
        setup(4'd15, 2'd1);
        repeat (4) send_request(OP_TICK, '0, '0, '0, '0, '0);

        // Receiver holds off while the sender keeps offering requests.
        hold_off = 1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (6) random_request();
        join
        drain();

        // Random phases of idling and stalling.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 74 : 30) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 74 : 30) : 0;
            setup(4'($urandom_range(15)), 2'($urandom_range(3)));
            repeat (8) random_request();
            drain();
        end

        if (sb.errors == 0 && sb.expected_hops.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
